// File: hw/rtl/wsd_pkg.sv
package wsd_pkg;

  // Length field handling
  localparam int unsigned LengthWidth = 64;
  localparam int unsigned RemWidth    = 64;
  localparam logic [RemWidth-1:0] LenBadMask =
      {1'b1, {(RemWidth-1){1'b0}}} | ({RemWidth{1'b1}} << LengthWidth);

  localparam logic [7:0]  RsvMask    = 8'h70;
  localparam logic [6:0]  Len16Code  = 7'd126;
  localparam logic [6:0]  Len64Code  = 7'd127;
  localparam logic [RemWidth-1:0] CtrlMaxLen = RemWidth'(125);
  localparam logic [3:0]  Ext16Bytes = 4'd2;
  localparam logic [3:0]  Ext64Bytes = 4'd8;
  localparam logic [3:0]  KeyBytes   = 4'd4;

  // Opcodes
  localparam logic [3:0] OpCont  = 4'h0;
  localparam logic [3:0] OpText  = 4'h1;
  localparam logic [3:0] OpBin   = 4'h2;
  localparam logic [3:0] OpClose = 4'h8;
  localparam logic [3:0] OpPing  = 4'h9;
  localparam logic [3:0] OpPong  = 4'ha;

  // Beat operation codes
  localparam logic OperByte  = 1'b0;
  localparam logic OperClose = 1'b1;

  typedef enum logic [2:0] {
    PH_HDR0     = 3'd0,
    PH_HDR1     = 3'd1,
    PH_EXT_LEN  = 3'd2,
    PH_MASK_KEY = 3'd3,
    PH_PAYLOAD  = 3'd4
  } phase_e;

  typedef enum logic [1:0] {
    LINK_CONNECTED = 2'd0,
    LINK_CLOSING   = 2'd1,
    LINK_CLOSED    = 2'd2,
    LINK_FAILED    = 2'd3
  } link_e;

  typedef enum logic [1:0] {
    FRAG_NONE = 2'd0,
    FRAG_TEXT = 2'd1,
    FRAG_BIN  = 2'd2
  } frag_e;

  typedef enum logic [2:0] {
    KIND_DATA  = 3'd0,
    KIND_PING  = 3'd1,
    KIND_PONG  = 3'd2,
    KIND_CLOSE = 3'd3,
    KIND_EVENT = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    EV_NONE        = 3'd0,
    EV_PROTO_ERR   = 3'd1,
    EV_CLOSE_REPLY = 3'd2,
    EV_SEND_PONG   = 3'd3,
    EV_LOCAL_CLOSE = 3'd4
  } event_e;

  typedef struct packed {
    logic       valid;
    kind_e      kind;
    logic [7:0] data;
    logic       binary;
    logic       eof;
    logic       eom;
    event_e     evt;
  } res_t;

endpackage

// File: hw/rtl/websocket_frame_deframer_core.sv
// WebSocket frame deframer core (receive side).
// Input channel: in_valid_i / in_stall_o carries one beat per item: operation_i
// selects a received link byte (in_byte_i) or a local request to close.
// Output channel: out_valid_o / out_stall_i carries at most one result beat per
// input beat: unmasked payload bytes tagged data, ping or pong, close-frame
// completion, and events (protocol error, close reply, send pong, local close)
// with end-of-frame and end-of-message marks.
// A beat moves when valid is high and stall is low.
// A taken beat sits in the input register until the parse logic loads its result
// into the result register, which a receiver stall can hold off.
// Throughput: one beat per cycle while the receiver does not stall, set by the
// single parse step between the input register and the result register; beats
// that give no result simply drop out of the flow.
// When the receiver stalls, the result register holds; the input register
// keeps one more beat, and only then is in_stall_o raised.
// Reset (rst_ni low, asynchronous) empties both registers and returns the
// parser to the first header byte with the link connected and no message open.
module websocket_frame_deframer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic       operation_i,
  input  logic [7:0] in_byte_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] out_kind_o,
  output logic [7:0] out_byte_o,
  output logic       message_binary_o,
  output logic       end_of_frame_o,
  output logic       end_of_message_o,
  output logic [2:0] event_res_o
);
  import wsd_pkg::*;

  // input register
  logic       in_valid_q, in_valid_d;
  logic       op_q;
  logic [7:0] byte_q;

  // result register
  logic       out_valid_q, out_valid_d;
  res_t       res_q;
  res_t       res;

  logic in_take;
  logic proc;

  // parse the held beat when the result register is empty or being drained
  assign proc       = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !proc;
  assign in_take    = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_take)   in_valid_d = 1'b1;
    else if (proc) in_valid_d = 1'b0;

    out_valid_d = out_valid_q;
    if (proc)              out_valid_d = res.valid;
    else if (!out_stall_i) out_valid_d = 1'b0;
  end

  wsd_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (proc),
    .op_i   (op_q),
    .byte_i (byte_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      op_q   <= operation_i;
      byte_q <= in_byte_i;
    end
    if (proc) res_q <= res;
  end

  assign out_valid_o      = out_valid_q;
  assign out_kind_o       = res_q.kind;
  assign out_byte_o       = res_q.data;
  assign message_binary_o = res_q.binary;
  assign end_of_frame_o   = res_q.eof;
  assign end_of_message_o = res_q.eom;
  assign event_res_o      = res_q.evt;

  a_stall_needs_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> in_valid_q && out_valid_q)
    else $error("input stalled with room to move");

  a_result_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(res_q))
    else $error("stalled result changed");

  a_error_ends_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && res_q.evt == EV_PROTO_ERR |-> res_q.kind == KIND_EVENT && res_q.eof)
    else $error("protocol error result malformed");

  a_eom_implies_eof: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && res_q.eom |-> res_q.eof)
    else $error("end of message without end of frame");

endmodule

// File: hw/rtl/wsd_parser.sv
module wsd_parser (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  logic          op_i,
  input  logic [7:0]    byte_i,
  output wsd_pkg::res_t res_o
);
  import wsd_pkg::*;

  phase_e                phase_q, phase_d;
  link_e                 link_q, link_d;
  frag_e                 frag_q, frag_d;
  logic                  fin_q, fin_d;
  logic [3:0]            op_q, op_d;
  logic                  mask_q, mask_d;
  logic [31:0]           key_q, key_d;
  logic [RemWidth-1:0]   rem_q, rem_d;
  logic [3:0]            hc_q, hc_d;
  logic [1:0]            mi_q, mi_d;

  logic ph_hdr0, ph_hdr1, ph_ext, ph_key, ph_pay;
  logic step, local_close, rsv_bad, ext_len, mask_new;
  logic len_done, hdr_done, hdr_bad, hdr_ok, do_fail;
  logic pay_step, pay_last, frame_end, data_op;
  frag_e frag_now;
  logic [7:0] v;
  logic [6:0] len7;

  // decode and datapath
  always_comb begin
    ph_hdr0 = 1'b0;
    ph_hdr1 = 1'b0;
    ph_ext  = 1'b0;
    ph_key  = 1'b0;
    ph_pay  = 1'b0;
    unique case (phase_q)
      PH_HDR1:     ph_hdr1 = 1'b1;
      PH_EXT_LEN:  ph_ext  = 1'b1;
      PH_MASK_KEY: ph_key  = 1'b1;
      PH_PAYLOAD:  ph_pay  = 1'b1;
      default:     ph_hdr0 = 1'b1;
    endcase

    len7        = byte_i[6:0];
    local_close = fire_i && (op_i == OperClose) && (link_q == LINK_CONNECTED);
    step        = fire_i && (op_i == OperByte) &&
                  (link_q == LINK_CONNECTED || link_q == LINK_CLOSING);
    rsv_bad     = (byte_i & RsvMask) != 8'h00;
    ext_len     = (len7 == Len16Code) || (len7 == Len64Code);
    mask_new    = ph_hdr1 ? byte_i[7] : mask_q;
    data_op     = (op_q == OpCont) || (op_q == OpText) || (op_q == OpBin);

    rem_d = rem_q;
    hc_d  = hc_q;
    key_d = key_q;
    if (step) begin
      if (ph_hdr1) begin
        rem_d = ext_len ? '0 : RemWidth'(len7);
        hc_d  = (len7 == Len16Code) ? Ext16Bytes : Ext64Bytes;
      end else if (ph_ext) begin
        rem_d = {rem_q[RemWidth-9:0], byte_i};
        hc_d  = hc_q - 4'd1;
      end else if (ph_key) begin
        key_d = {key_q[23:0], byte_i};
        hc_d  = hc_q - 4'd1;
      end else if (ph_pay) begin
        rem_d = rem_q - RemWidth'(1);
      end
    end

    len_done = step && ((ph_hdr1 && !ext_len) || (ph_ext && hc_d == 4'd0));
    if (len_done && mask_new) begin
      hc_d  = KeyBytes;
      key_d = '0;
    end
    hdr_done = (len_done && !mask_new) || (step && ph_key && hc_d == 4'd0);

    hdr_bad = (rem_d & LenBadMask) != '0;
    case (op_q) inside
      OpCont:               if (frag_q == FRAG_NONE) hdr_bad = 1'b1;
      OpText, OpBin:        if (frag_q != FRAG_NONE) hdr_bad = 1'b1;
      OpClose, OpPing, OpPong: if (!fin_q || rem_d > CtrlMaxLen) hdr_bad = 1'b1;
      default:              hdr_bad = 1'b1;
    endcase

    hdr_ok    = hdr_done && !hdr_bad;
    do_fail   = (step && ph_hdr0 && rsv_bad) || (hdr_done && hdr_bad);
    frag_now  = (hdr_ok && (op_q == OpText || op_q == OpBin)) ? frag_e'(op_q[1:0]) : frag_q;
    pay_step  = step && ph_pay;
    pay_last  = pay_step && (rem_d == '0);
    frame_end = (hdr_ok && rem_d == '0) || pay_last;

    // mask byte 0 sits in the top byte of the key
    v = byte_i ^ (mask_q ? key_q[{~mi_q, 3'b000} +: 8] : 8'h00);
  end

  // next state
  always_comb begin
    phase_d = phase_q;
    link_d  = link_q;
    frag_d  = frag_now;
    fin_d   = fin_q;
    op_d    = op_q;
    mask_d  = mask_new;
    mi_d    = mi_q;

    if (step) begin
      if (ph_hdr0) begin
        phase_d = PH_HDR1;
        if (!rsv_bad) begin
          fin_d = byte_i[7];
          op_d  = byte_i[3:0];
        end
      end else if (ph_hdr1 && ext_len) begin
        phase_d = PH_EXT_LEN;
      end
      if (len_done && mask_new) phase_d = PH_MASK_KEY;
      if (hdr_ok) begin
        phase_d = PH_PAYLOAD;
        mi_d    = 2'd0;
      end
      if (pay_step) mi_d = mi_q + 2'd1;
    end

    if (frame_end) begin
      phase_d = PH_HDR0;
      if (data_op && fin_q) frag_d = FRAG_NONE;
      if (op_q == OpClose) link_d = LINK_CLOSED;
    end
    if (do_fail) begin
      phase_d = PH_HDR0;
      link_d  = LINK_FAILED;
    end
    if (local_close) link_d = LINK_CLOSING;
  end

  // result
  always_comb begin
    res_o = '0;
    if (local_close) begin
      res_o.valid = 1'b1;
      res_o.kind  = KIND_EVENT;
      res_o.evt   = EV_LOCAL_CLOSE;
    end else if (do_fail) begin
      res_o.valid = 1'b1;
      res_o.kind  = KIND_EVENT;
      res_o.eof   = 1'b1;
      res_o.evt   = EV_PROTO_ERR;
    end else if (frame_end) begin
      res_o.valid = 1'b1;
      res_o.eof   = 1'b1;
      case (op_q) inside
        OpCont, OpText, OpBin: begin
          res_o.kind   = pay_last ? KIND_DATA : KIND_EVENT;
          res_o.data   = pay_last ? v : 8'h00;
          res_o.binary = (frag_now == FRAG_BIN);
          res_o.eom    = fin_q;
        end
        OpPing: begin
          res_o.kind = pay_last ? KIND_PING : KIND_EVENT;
          res_o.data = pay_last ? v : 8'h00;
          res_o.evt  = EV_SEND_PONG;
        end
        OpPong: begin
          res_o.kind = pay_last ? KIND_PONG : KIND_EVENT;
          res_o.data = pay_last ? v : 8'h00;
        end
        default: begin
          res_o.kind = KIND_CLOSE;
          res_o.evt  = (link_q == LINK_CONNECTED) ? EV_CLOSE_REPLY : EV_NONE;
        end
      endcase
    end else if (pay_step) begin
      case (op_q) inside
        OpCont, OpText, OpBin: begin
          res_o.valid  = 1'b1;
          res_o.kind   = KIND_DATA;
          res_o.data   = v;
          res_o.binary = (frag_q == FRAG_BIN);
        end
        OpPing: begin
          res_o.valid = 1'b1;
          res_o.kind  = KIND_PING;
          res_o.data  = v;
        end
        OpPong: begin
          res_o.valid = 1'b1;
          res_o.kind  = KIND_PONG;
          res_o.data  = v;
        end
        default: res_o.valid = 1'b0;  // close payload dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HDR0;
      link_q  <= LINK_CONNECTED;
      frag_q  <= FRAG_NONE;
      fin_q   <= 1'b0;
      op_q    <= OpCont;
      mask_q  <= 1'b0;
      key_q   <= '0;
      rem_q   <= '0;
      hc_q    <= '0;
      mi_q    <= '0;
    end else begin
      phase_q <= phase_d;
      link_q  <= link_d;
      frag_q  <= frag_d;
      fin_q   <= fin_d;
      op_q    <= op_d;
      mask_q  <= mask_d;
      key_q   <= key_d;
      rem_q   <= rem_d;
      hc_q    <= hc_d;
      mi_q    <= mi_d;
    end
  end

  // once failed or closed, nothing but nothing comes out
  a_dead_link_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (link_q == LINK_FAILED || link_q == LINK_CLOSED) |-> !res_o.valid)
    else $error("result produced on a dead link");

  a_fail_sticks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    link_q == LINK_FAILED |=> link_q == LINK_FAILED)
    else $error("failed link state left");

  a_payload_has_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_PAYLOAD |-> rem_q != '0)
    else $error("payload phase with zero remaining bytes");

endmodule

// File: test/tb_websocket_frame_deframer_core.sv
module tb_websocket_frame_deframer_core;
  timeunit 1ns;
  timeprecision 1ps;

  import wsd_pkg::*;

  // One link beat as the sender presents it.
  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } link_beat_t;

  // One deframed result beat, field by field as the output ports carry it.
  typedef struct packed {
    kind_e      kind;
    logic [7:0] data;
    logic       binary;
    logic       eof;
    logic       eom;
    event_e     evt;
  } deframed_t;

  // Encodings of the payload length in the second header byte.
  typedef enum logic [1:0] {
    FORM_SHORT = 2'd0,
    FORM_EXT16 = 2'd1,
    FORM_EXT64 = 2'd2
  } len_form_e;

  localparam int unsigned RandomBeats = 950;
  localparam int unsigned TailBeats   = 120;  // no idling once this few are left
  localparam int unsigned QuietLimit  = 2000; // cycles without any beat moving
  localparam int unsigned DrainCycles = 8;

  // DUT-facing signals; the ones the bench drives are known from time zero.
  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid    = 1'b0;
  logic       in_stall;
  logic       operation   = OperByte;
  logic [7:0] in_byte     = 8'h00;
  logic       out_valid;
  logic       out_stall   = 1'b0;
  logic [2:0] out_kind;
  logic [7:0] out_byte;
  logic       out_binary;
  logic       out_eof;
  logic       out_eom;
  logic [2:0] out_event;

  // Stimulus and scoreboard storage.
  link_beat_t  link_beats[$];
  deframed_t   deframed_q[$];
  link_beat_t  next_beat;
  deframed_t   got_head;
  logic        in_taken       = 1'b0;
  int unsigned src_gap        = 0;
  int unsigned sink_gap       = 0;
  int unsigned quiet_cycles   = 0;
  int unsigned mismatch_count = 0;
  logic        tail_calm;

  // Generator bookkeeping: whether a fragmented message is open, and when
  // the single effective local close request gets slipped into the stream.
  logic        gen_open    = 1'b0;
  logic        gen_closing = 1'b0;
  logic        close_armed = 1'b0;
  int unsigned close_at    = 0;

  // Predictor state, at reset values (reset is applied once only).
  phase_e      hdr_phase  = PH_HDR0;
  link_e       link_st    = LINK_CONNECTED;
  logic        cur_fin    = 1'b0;
  logic [3:0]  cur_op     = OpCont;
  logic        cur_masked = 1'b0;
  logic [31:0] cur_key    = '0;
  logic [63:0] bytes_left = '0;
  logic [3:0]  hdr_left   = '0;
  logic [1:0]  key_idx    = '0;
  frag_e       msg_open   = FRAG_NONE;

  assign tail_calm = (link_beats.size() < TailBeats);

  websocket_frame_deframer_core DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid),
    .in_stall_o       (in_stall),
    .operation_i      (operation),
    .in_byte_i        (in_byte),
    .out_valid_o      (out_valid),
    .out_stall_i      (out_stall),
    .out_kind_o       (out_kind),
    .out_byte_o       (out_byte),
    .message_binary_o (out_binary),
    .end_of_frame_o   (out_eof),
    .end_of_message_o (out_eom),
    .event_res_o      (out_event)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // ------------------------------------------------------------------
  // Predictor
  // ------------------------------------------------------------------

  task automatic push_result(input kind_e k, input logic [7:0] d, input logic bin,
                             input logic eof, input logic eom, input event_e ev);
    deframed_t r;
    r.kind   = k;
    r.data   = d;
    r.binary = bin;
    r.eof    = eof;
    r.eom    = eom;
    r.evt    = ev;
    deframed_q.push_back(r);
  endtask

  // Protocol error: link is dead from here on.
  task automatic proto_fail();
    link_st   = LINK_FAILED;
    hdr_phase = PH_HDR0;
    push_result(KIND_EVENT, 8'h00, 1'b0, 1'b1, 1'b0, EV_PROTO_ERR);
  endtask

  // Last result of a frame; has_byte says whether a payload byte rides on it.
  task automatic frame_finish(input logic has_byte, input logic [7:0] v);
    logic  bin;
    logic  eom;
    event_e ev;
    hdr_phase = PH_HDR0;
    if (cur_op <= OpBin) begin
      bin = (msg_open == FRAG_BIN);
      eom = cur_fin;
      if (cur_fin) msg_open = FRAG_NONE;
      push_result(has_byte ? KIND_DATA : KIND_EVENT, has_byte ? v : 8'h00, bin,
                  1'b1, eom, EV_NONE);
    end else if (cur_op == OpPing) begin
      push_result(has_byte ? KIND_PING : KIND_EVENT, has_byte ? v : 8'h00, 1'b0,
                  1'b1, 1'b0, EV_SEND_PONG);
    end else if (cur_op == OpPong) begin
      push_result(has_byte ? KIND_PONG : KIND_EVENT, has_byte ? v : 8'h00, 1'b0,
                  1'b1, 1'b0, EV_NONE);
    end else begin
      // Close frame: reply only if we did not start the close ourselves.
      ev = (link_st == LINK_CONNECTED) ? EV_CLOSE_REPLY : EV_NONE;
      link_st = LINK_CLOSED;
      push_result(KIND_CLOSE, 8'h00, 1'b0, 1'b1, 1'b0, ev);
    end
  endtask

  // Frame rules, checked once the whole header is in.
  task automatic header_check();
    logic bad;
    bad = ((bytes_left & LenBadMask) != '0);
    case (cur_op)
      OpCont: begin
        if (msg_open == FRAG_NONE) bad = 1'b1;
      end
      OpText, OpBin: begin
        if (msg_open != FRAG_NONE) bad = 1'b1;
      end
      OpClose, OpPing, OpPong: begin
        if (!cur_fin || bytes_left > CtrlMaxLen) bad = 1'b1;
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      proto_fail();
    end else begin
      if (cur_op == OpText) msg_open = FRAG_TEXT;
      if (cur_op == OpBin) msg_open = FRAG_BIN;
      key_idx = '0;
      if (bytes_left == '0) frame_finish(1'b0, 8'h00);
      else hdr_phase = PH_PAYLOAD;
    end
  endtask

  task automatic length_check();
    if (cur_masked) begin
      hdr_left  = KeyBytes;
      cur_key   = '0;
      hdr_phase = PH_MASK_KEY;
    end else begin
      header_check();
    end
  endtask

  // One accepted link beat through the deframer.
  task automatic deframe_step(input logic op, input logic [7:0] b);
    logic [7:0] v;
    int         sh;
    if (op == OperClose) begin
      if (link_st == LINK_CONNECTED) begin
        link_st = LINK_CLOSING;
        push_result(KIND_EVENT, 8'h00, 1'b0, 1'b0, 1'b0, EV_LOCAL_CLOSE);
      end
    end else if (link_st != LINK_CLOSED && link_st != LINK_FAILED) begin
      case (hdr_phase)
        PH_HDR1: begin
          cur_masked = b[7];
          bytes_left = '0;
          if (b[6:0] == Len16Code || b[6:0] == Len64Code) begin
            hdr_left  = (b[6:0] == Len16Code) ? Ext16Bytes : Ext64Bytes;
            hdr_phase = PH_EXT_LEN;
          end else begin
            bytes_left = {57'd0, b[6:0]};
            length_check();
          end
        end
        PH_EXT_LEN: begin
          bytes_left = {bytes_left[55:0], b};
          hdr_left   = hdr_left - 4'd1;
          if (hdr_left == '0) length_check();
        end
        PH_MASK_KEY: begin
          cur_key  = {cur_key[23:0], b};
          hdr_left = hdr_left - 4'd1;
          if (hdr_left == '0) header_check();
        end
        PH_PAYLOAD: begin
          v  = b;
          sh = 8 * (3 - int'(key_idx));
          if (cur_masked) v = v ^ cur_key[sh +: 8];
          key_idx    = key_idx + 2'd1;
          bytes_left = bytes_left - 64'd1;
          if (bytes_left == '0) begin
            frame_finish(1'b1, v);
          end else if (cur_op <= OpBin) begin
            push_result(KIND_DATA, v, msg_open == FRAG_BIN, 1'b0, 1'b0, EV_NONE);
          end else if (cur_op == OpPing) begin
            push_result(KIND_PING, v, 1'b0, 1'b0, 1'b0, EV_NONE);
          end else if (cur_op == OpPong) begin
            push_result(KIND_PONG, v, 1'b0, 1'b0, 1'b0, EV_NONE);
          end
          // close payload bytes are swallowed
        end
        default: begin
          if ((b & RsvMask) != 8'h00) begin
            proto_fail();
          end else begin
            cur_fin   = b[7];
            cur_op    = b[3:0];
            hdr_phase = PH_HDR1;
          end
        end
      endcase
    end
  endtask

  // ------------------------------------------------------------------
  // Stimulus helpers
  // ------------------------------------------------------------------

  // Payload and key bytes, biased toward the all-zero and all-one extremes.
  function automatic logic [7:0] rand_byte();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? 8'hff : 8'h00;
    return 8'($urandom);
  endfunction

  // Queue one beat; a local close request may be slipped in ahead of a byte.
  task automatic push_beat(input logic op, input logic [7:0] data);
    link_beat_t lb;
    if (op == OperByte) begin
      if (close_armed && link_beats.size() >= close_at) begin
        close_armed = 1'b0;
        gen_closing = 1'b1;
        lb.op = OperClose;
        lb.data = 8'($urandom);
        link_beats.push_back(lb);
      end else if (gen_closing && $urandom_range(0, 199) == 0) begin
        // already closing: this request must be dropped without a result
        lb.op = OperClose;
        lb.data = 8'($urandom);
        link_beats.push_back(lb);
      end
    end
    lb.op   = op;
    lb.data = data;
    link_beats.push_back(lb);
  endtask

  // Queue a frame header and, unless hdr_only, its payload.
  task automatic push_frame(input logic fin, input logic [3:0] opc, input logic [63:0] len,
                            input len_form_e form, input logic masked,
                            input logic hdr_only);
    push_beat(OperByte, {fin, 3'b000, opc});
    case (form)
      FORM_SHORT: push_beat(OperByte, {masked, len[6:0]});
      FORM_EXT16: begin
        push_beat(OperByte, {masked, Len16Code});
        push_beat(OperByte, len[15:8]);
        push_beat(OperByte, len[7:0]);
      end
      default: begin
        push_beat(OperByte, {masked, Len64Code});
        for (int i = 7; i >= 0; i--) push_beat(OperByte, len[8*i +: 8]);
      end
    endcase
    if (masked) begin
      for (int i = 0; i < 4; i++) push_beat(OperByte, rand_byte());
    end
    if (!hdr_only) begin
      for (longint unsigned n = 0; n < len; n++) push_beat(OperByte, rand_byte());
      if (opc == OpText || opc == OpBin) gen_open = !fin;
      if (opc == OpCont && fin) gen_open = 1'b0;
    end
  endtask

  // ------------------------------------------------------------------
  // Driver: new beat at the falling edge once the previous one moved.
  // ------------------------------------------------------------------
  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid || in_taken)) begin
      if (src_gap > 0) begin
        in_valid <= 1'b0;
        src_gap  <= src_gap - 1;
      end else if (link_beats.size() > 0) begin
        next_beat = link_beats.pop_front();
        in_valid  <= 1'b1;
        operation <= next_beat.op;
        in_byte   <= next_beat.data;
        if (!tail_calm && $urandom_range(0, 15) == 0) src_gap <= $urandom_range(1, 17);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver stall bursts at random, none in the tail.
  always @(negedge clk_i) begin
    if (sink_gap > 0) begin
      out_stall <= 1'b1;
      sink_gap  <= sink_gap - 1;
    end else if (!tail_calm && $urandom_range(0, 19) == 0) begin
      out_stall <= 1'b1;
      sink_gap  <= $urandom_range(0, 16);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // ------------------------------------------------------------------
  // Monitor: sample both channels at the rising edge.
  // ------------------------------------------------------------------
  task automatic check_field(input string name, input int exp_v, input int act_v);
    if (exp_v != act_v) begin
      $error("%s: expected %0d, actual %0d", name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  always @(posedge clk_i) begin
    in_taken <= in_valid && !in_stall;
    if (rst_ni) begin
      if (in_valid && !in_stall) deframe_step(operation, in_byte);
      if (out_valid && !out_stall) begin
        if (deframed_q.size() == 0) begin
          $error("out_kind: expected no result beat, actual %0d", out_kind);
          mismatch_count++;
        end else begin
          got_head = deframed_q.pop_front();
          check_field("out_kind", got_head.kind, out_kind);
          check_field("out_byte", got_head.data, out_byte);
          check_field("message_binary", got_head.binary, out_binary);
          check_field("end_of_frame", got_head.eof, out_eof);
          check_field("end_of_message", got_head.eom, out_eom);
          check_field("event_res", got_head.evt, out_event);
        end
      end
      // Watchdog: nothing moving on either side for too long.
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QuietLimit) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // ------------------------------------------------------------------
  // Sequence: fill the beat queue, release reset, wait for drain.
  // ------------------------------------------------------------------
  initial begin
    int unsigned rand_goal;
    int unsigned len;
    int unsigned pick;
    logic [3:0]  opc;
    logic        fin;
    len_form_e   form;

    // Directed: empty text frame, masked binary fragment, ping inside the
    // message, continuation with a 16-bit length, empty pong.
    push_frame(1'b1, OpText, 64'd0, FORM_SHORT, 1'b0, 1'b0);
    push_frame(1'b0, OpBin,  64'd1, FORM_SHORT, 1'b1, 1'b0);
    push_frame(1'b1, OpPing, 64'd1, FORM_SHORT, 1'b0, 1'b0);
    push_frame(1'b1, OpCont, 64'd1, FORM_EXT16, 1'b0, 1'b0);
    push_frame(1'b1, OpPong, 64'd0, FORM_SHORT, 1'b0, 1'b0);

    // Random well-formed traffic. The link survives only until the first
    // close or error, so the body stays legal and the ending is terminal.
    rand_goal   = link_beats.size() + RandomBeats;
    close_at    = link_beats.size() + $urandom_range(0, 1400);
    close_armed = 1'b1;
    while (link_beats.size() < rand_goal) begin
      if ($urandom_range(0, 4) == 0) begin
        opc = $urandom_range(0, 1) ? OpPing : OpPong;
        fin = 1'b1;
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(100, 125) : $urandom_range(0, 6);
      end else begin
        opc = gen_open ? OpCont : ($urandom_range(0, 1) ? OpBin : OpText);
        fin = ($urandom_range(0, 2) != 0);
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(126, 400) : $urandom_range(0, 12);
      end
      pick = $urandom_range(0, 7);
      if (pick == 0 || len > 125) form = FORM_EXT16;
      else if (pick == 1) form = FORM_EXT64;
      else form = FORM_SHORT;
      if (len > 125 && $urandom_range(0, 3) == 0) form = FORM_EXT64;
      push_frame(fin, opc, 64'(len), form, 1'($urandom_range(0, 1)), 1'b0);
    end
    close_armed = 1'b0;

    // Terminal case, picked by the seed.
    case ($urandom_range(0, 6))
      0: begin
        // reserved bits set in the first header byte
        push_beat(OperByte, {1'($urandom), 3'($urandom_range(1, 7)), 4'($urandom)});
      end
      1: begin
        // 64-bit length with its top bit set
        push_frame(1'b1, gen_open ? OpCont : OpBin, {1'b1, 63'($urandom)} ^ 64'($urandom),
                   FORM_EXT64, 1'($urandom), 1'b1);
      end
      2: begin
        // reserved opcode
        opc = $urandom_range(0, 1) ? OpBin + 4'($urandom_range(1, 5))
                                   : OpPong + 4'($urandom_range(1, 5));
        push_frame(1'($urandom), opc, 64'($urandom_range(0, 5)), FORM_SHORT,
                   1'($urandom), 1'b1);
      end
      3: begin
        // fragment order broken either way
        if (gen_open) opc = $urandom_range(0, 1) ? OpText : OpBin;
        else opc = OpCont;
        push_frame(1'($urandom), opc, 64'($urandom_range(0, 5)), FORM_SHORT,
                   1'($urandom), 1'b1);
      end
      4: begin
        // control frame without FIN
        pick = $urandom_range(0, 2);
        opc  = (pick == 0) ? OpClose : ((pick == 1) ? OpPing : OpPong);
        push_frame(1'b0, opc, 64'($urandom_range(0, 5)), FORM_SHORT, 1'($urandom), 1'b1);
      end
      5: begin
        // control frame longer than 125 bytes
        pick = $urandom_range(0, 2);
        opc  = (pick == 0) ? OpClose : ((pick == 1) ? OpPing : OpPong);
        push_frame(1'b1, opc, 64'($urandom_range(126, 300)), FORM_EXT16,
                   1'($urandom), 1'b1);
      end
      default: begin
        // clean close frame, payload dropped
        push_frame(1'b1, OpClose, 64'($urandom_range(0, 6)),
                   $urandom_range(0, 3) == 0 ? FORM_EXT16 : FORM_SHORT,
                   1'($urandom), 1'b0);
      end
    endcase

    // Dead link: everything after must be ignored, close requests included.
    for (int i = 0; i < 12; i++) push_beat(1'($urandom), 8'($urandom));

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    do @(posedge clk_i); while (link_beats.size() != 0 || in_valid);
    while (deframed_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
